// ----- src/gsfz_pkg.sv -----
// Shared types and constants of the Gouraud span fill core with depth buffer.
`timescale 1ns / 1ps
package gsfz_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SPAN  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;

   localparam int CSR_DW        = 9;
   localparam int LEN_W         = 12;
   localparam int VAL_W         = 16;
   localparam int DIVIDEND_W    = 27;
   localparam int NUM_CH        = 4;
   localparam logic [CSR_DW-1:0] CSR_RESET = 9'd256;
   localparam logic [VAL_W-1:0]  DEPTH_FAR = 16'hFFFF;

endpackage

// ----- src/gouraud_span_fill_zbuffer_core.sv -----
// Top level of the Gouraud span fill core with depth and RGB565 color stores.
`timescale 1ns / 1ps
// Usage
//   Issue a transaction by raising start with the req_ fields while busy is low; it is
//   taken at that clock edge. Exactly one result follows on the rsp_ ports, marked by
//   rsp_valid for a single cycle; the receiver cannot stall it and must take it then.
//   csr_we writes width (index 0) or height (index 1); write only while idle.
// Sequence
//   Read pixel: the stores are read at acceptance into depth_q_ff/color_q_ff, then S_RD registers the result.
//   Skipped span, out-of-range read, unused opcode: result in the cycle after acceptance.
//   Clear: all SCREEN_WIDTH*SCREEN_HEIGHT store entries, one written per cycle, and
//   the result in the cycle after the last entry is written.
//   Visible span: eight 27-bit serial divisions in the shared divider (start offset and
//   per-pixel step for depth, red, green, blue), then a depth read-modify-write for each
//   visible pixel, in states S_PXRD and S_PXWR.
// Reset
//   Reset restores both registers to 256 and starts a clearing pass over all
//   SCREEN_WIDTH*SCREEN_HEIGHT store entries; busy stays high until it ends and no
//   result is produced for it.
module gouraud_span_fill_zbuffer_core #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [7:0]                 req_row,
   input  logic signed [10:0]         req_x_start,
   input  logic signed [10:0]         req_x_end,
   input  logic [15:0]                req_z_start,
   input  logic [15:0]                req_z_end,
   input  logic [7:0]                 req_red_start,
   input  logic [7:0]                 req_red_end,
   input  logic [7:0]                 req_green_start,
   input  logic [7:0]                 req_green_end,
   input  logic [7:0]                 req_blue_start,
   input  logic [7:0]                 req_blue_end,
   output logic                       rsp_valid,
   output logic [8:0]                 rsp_pixels_written,
   output logic [15:0]                rsp_read_color,
   output logic [15:0]                rsp_read_depth,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [8:0]                 csr_wdata
);

   localparam int STORE = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(STORE);
   localparam int XW    = $clog2(SCREEN_WIDTH);
   localparam int LW    = gsfz_pkg::LEN_W;
   localparam int VW    = gsfz_pkg::VAL_W;
   localparam int DW    = gsfz_pkg::DIVIDEND_W;
   localparam int NC    = gsfz_pkg::NUM_CH;
   localparam logic [10:0]   WMAX     = 11'(SCREEN_WIDTH);
   localparam logic [10:0]   HMAX     = 11'(SCREEN_HEIGHT);
   localparam logic [AW-1:0] LAST_ADR = AW'(STORE - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CLR, S_RD, S_DLD, S_DRUN, S_PXRD, S_PXWR
   } state_type;

   state_type state_ff;

   // configuration
   logic [8:0] width_ff, height_ff;

   // stores: one entry per pixel, addressed row*SCREEN_WIDTH + column
   logic [VW-1:0] depth_store_ff [STORE];
   logic [VW-1:0] color_store_ff [STORE];
   logic [VW-1:0] depth_q_ff, color_q_ff;

   // span context
   logic [AW-1:0]    clr_ff, base_ff;
   logic [XW-1:0]    x_ff, hi_ff;
   logic [LW-1:0]    len_ff;
   logic [10:0]      t0_ff;
   logic [8:0]       count_ff;
   logic             clr_rsp_ff;
   logic [VW-1:0]    start_ff [NC];
   logic [VW-1:0]    mag_ff   [NC];
   logic             neg_ff   [NC];
   logic [VW-1:0]    q_ff     [NC];
   logic [LW-1:0]    r_ff     [NC];
   logic [VW-1:0]    qstep_ff [NC];
   logic [LW-1:0]    rstep_ff [NC];

   // shared serial divider
   logic [2:0]       job_ff;
   logic [4:0]       cnt_ff;
   logic [DW-1:0]    num_ff;
   logic [LW-1:0]    rem_ff;

   // response registers
   logic             rsp_valid_ff;
   logic [8:0]       rsp_pw_ff;
   logic [VW-1:0]    rsp_color_ff, rsp_depth_ff;

   // acceptance-time decode
   logic signed [11:0] xs12, xe12, lo12, hi12, wm1;
   logic [10:0]        w_eff, h_eff;
   logic               row_ok, span_ok, rd_ok, accept;
   logic [AW-1:0]      row_base, rd_addr;
   logic [VW-1:0]      req_a [NC];
   logic [VW-1:0]      req_b [NC];

   // pixel datapath
   logic [VW-1:0]      val [NC];
   logic [VW-1:0]      z_cur, color_cur;
   logic [AW-1:0]      pix_addr, mem_addr;
   logic               mem_we, z_pass;
   logic [VW-1:0]      mem_dw, mem_cw;

   // divider step
   logic [1:0]         ch;
   logic [LW:0]        div_shift;
   logic               div_ge;
   logic [LW-1:0]      div_rem;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      w_eff   = ({2'b0, width_ff}  > WMAX) ? WMAX : {2'b0, width_ff};
      h_eff   = ({2'b0, height_ff} > HMAX) ? HMAX : {2'b0, height_ff};
      xs12    = {req_x_start[10], req_x_start};
      xe12    = {req_x_end[10], req_x_end};
      wm1     = $signed({1'b0, w_eff}) - 12'sd1;
      lo12    = xs12[11] ? 12'sd0 : xs12;
      hi12    = (xe12 < wm1) ? xe12 : wm1;
      row_ok  = ({3'b0, req_row} < h_eff);
      span_ok = (xe12 >= xs12) && row_ok && (lo12 <= hi12);
      rd_ok   = !xs12[11] && (xs12 < $signed({1'b0, w_eff})) && row_ok;
      row_base = AW'(32'(req_row) * SCREEN_WIDTH);
      rd_addr  = row_base + AW'(xs12[10:0]);
      req_a[0] = req_z_start;              req_b[0] = req_z_end;
      req_a[1] = {8'b0, req_red_start};    req_b[1] = {8'b0, req_red_end};
      req_a[2] = {8'b0, req_green_start};  req_b[2] = {8'b0, req_green_end};
      req_a[3] = {8'b0, req_blue_start};   req_b[3] = {8'b0, req_blue_end};
   end

   // interpolated values: start +/- truncated quotient magnitude
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         val[c] = neg_ff[c] ? (start_ff[c] - q_ff[c]) : (start_ff[c] + q_ff[c]);
      end
      z_cur     = val[0];
      color_cur = {val[1][7:3], val[2][7:2], val[3][7:3]};
      pix_addr  = base_ff + AW'(x_ff);
      z_pass    = (z_cur <= depth_q_ff);
   end

   // restoring division step: one quotient bit per cycle
   always_comb begin
      ch        = job_ff[2:1];
      div_shift = {rem_ff, num_ff[DW-1]};
      div_ge    = (div_shift >= {1'b0, len_ff});
      div_rem   = div_ge ? LW'(div_shift - {1'b0, len_ff}) : LW'(div_shift);
   end

   // store port control
   always_comb begin
      mem_addr = rd_addr;
      mem_we   = 1'b0;
      mem_dw   = gsfz_pkg::DEPTH_FAR;
      mem_cw   = '0;
      case (state_ff)
         S_CLR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
         end
         S_PXRD: begin
            mem_addr = pix_addr;
         end
         S_PXWR: begin
            mem_addr = pix_addr;
            mem_we   = z_pass;
            mem_dw   = z_cur;
            mem_cw   = color_cur;
         end
         default: begin
            mem_addr = rd_addr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_store_ff[mem_addr] <= mem_dw;
         color_store_ff[mem_addr] <= mem_cw;
      end
      depth_q_ff <= depth_store_ff[mem_addr];
      color_q_ff <= color_store_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         width_ff     <= gsfz_pkg::CSR_RESET;
         height_ff    <= gsfz_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == gsfz_pkg::CSR_WIDTH_IDX) begin
               width_ff <= csr_wdata;
            end else begin
               height_ff <= csr_wdata;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_pw_ff    <= '0;
                  rsp_color_ff <= '0;
                  rsp_depth_ff <= '0;
                  case (gsfz_pkg::opcode_type'(req_opcode))
                     gsfz_pkg::OP_CLEAR: begin
                        clr_ff     <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLR;
                     end
                     gsfz_pkg::OP_SPAN: begin
                        if (span_ok) begin
                           base_ff  <= row_base;
                           x_ff     <= XW'(lo12);
                           hi_ff    <= XW'(hi12);
                           len_ff   <= LW'(xe12 - xs12 + 12'sd1);
                           t0_ff    <= 11'(lo12 - xs12);
                           count_ff <= '0;
                           job_ff   <= '0;
                           for (int c = 0; c < NC; c++) begin
                              start_ff[c] <= req_a[c];
                              neg_ff[c]   <= (req_b[c] < req_a[c]);
                              mag_ff[c]   <= (req_b[c] < req_a[c]) ? (req_a[c] - req_b[c])
                                                                  : (req_b[c] - req_a[c]);
                           end
                           state_ff <= S_DLD;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     gsfz_pkg::OP_READ: begin
                        if (rd_ok) begin
                           state_ff <= S_RD;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_ADR) begin
                  rsp_valid_ff <= clr_rsp_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_RD: begin
               rsp_color_ff <= color_q_ff;
               rsp_depth_ff <= depth_q_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_DLD: begin
               // even job: start offset |d|*t0/len, odd job: step |d|/len
               num_ff   <= job_ff[0] ? DW'(mag_ff[ch]) : DW'(mag_ff[ch]) * DW'(t0_ff);
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DRUN;
            end
            S_DRUN: begin
               num_ff <= {num_ff[DW-2:0], div_ge};
               rem_ff <= div_rem;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(DW - 1)) begin
                  if (job_ff[0]) begin
                     qstep_ff[ch] <= VW'({num_ff[DW-2:0], div_ge});
                     rstep_ff[ch] <= div_rem;
                  end else begin
                     q_ff[ch] <= VW'({num_ff[DW-2:0], div_ge});
                     r_ff[ch] <= div_rem;
                  end
                  job_ff   <= job_ff + 1'b1;
                  state_ff <= (job_ff == 3'(2 * NC - 1)) ? S_PXRD : S_DLD;
               end
            end
            S_PXRD: begin
               state_ff <= S_PXWR;
            end
            S_PXWR: begin
               if (z_pass) begin
                  count_ff <= count_ff + 1'b1;
               end
               // advance every channel by one column
               for (int c = 0; c < NC; c++) begin
                  if (({1'b0, r_ff[c]} + {1'b0, rstep_ff[c]}) >= {1'b0, len_ff}) begin
                     r_ff[c] <= LW'({1'b0, r_ff[c]} + {1'b0, rstep_ff[c]} - {1'b0, len_ff});
                     q_ff[c] <= q_ff[c] + qstep_ff[c] + 1'b1;
                  end else begin
                     r_ff[c] <= r_ff[c] + rstep_ff[c];
                     q_ff[c] <= q_ff[c] + qstep_ff[c];
                  end
               end
               x_ff <= x_ff + 1'b1;
               if (x_ff == hi_ff) begin
                  rsp_pw_ff    <= z_pass ? (count_ff + 1'b1) : count_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_PXRD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixels_written = rsp_pw_ff;
   assign rsp_read_color     = rsp_color_ff;
   assign rsp_read_depth     = rsp_depth_ff;

   // a result never shows while a transaction is still in progress
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   // every accepted transaction either answers at once or goes busy
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy)) else $error("transaction dropped");

   // a result carries either a pixel count or read data, never both
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixels_written == 9'd0 ||
                     (rsp_read_color == 16'd0 && rsp_read_depth == 16'd0)))
      else $error("mixed result fields");

endmodule
